// ===== rtl/core/ssd_pkg.sv =====
// shared widths, controller states and command/status types for the divisibility unit
package ssd_pkg;

   localparam int VALUE_W = 16;
   localparam int MOD_W   = 8;
   localparam int CNT_W   = $clog2(VALUE_W);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_FIX    = 5'b00100,
      ST_ROTP   = 5'b01000,
      ST_COMMIT = 5'b10000
   } ssd_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic fix;
      logic rot_plus;
      logic commit;
      logic rsp_load;
   } ssd_cmd_type;

   typedef struct packed {
      logic item_last;
   } ssd_status_type;

endpackage

// ===== rtl/core/ssd_datapath.sv =====
// datapath: modulus register, iterative residue unit, shared rotator and residue set
module ssd_datapath #(
   parameter int MAX_MODULUS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ssd_pkg::ssd_cmd_type            cmd,
   output ssd_pkg::ssd_status_type         status,
   input  logic signed [ssd_pkg::VALUE_W-1:0] req_value,
   input  logic                            req_first_item,
   input  logic                            req_last_item,
   input  logic                            csr_write_enable,
   input  logic [ssd_pkg::MOD_W-1:0]       csr_write_data,
   output logic                            rsp_divisible
);
   import ssd_pkg::*;

   logic [MOD_W-1:0]       modulus_ff, modulus_in;
   logic [VALUE_W-1:0]     quo_ff, quo_in;
   logic [MOD_W-1:0]       rem_ff, rem_in;
   logic [MOD_W-1:0]       res_ff, res_in;
   logic                   neg_ff, neg_in;
   logic                   first_ff, first_in;
   logic                   last_ff, last_in;
   logic [MAX_MODULUS-1:0] set_ff, set_in;
   logic [MAX_MODULUS-1:0] plus_ff, plus_in;
   logic                   divisible_ff, divisible_in;

   logic [VALUE_W-1:0]     magnitude;
   logic [MOD_W:0]         rem_shift;
   logic                   rem_ge;
   logic [MAX_MODULUS-1:0] valid_mask;
   logic [MAX_MODULUS-1:0] set_masked;
   logic [MOD_W-1:0]       rot_amt;
   logic [MAX_MODULUS-1:0] rot_out;
   logic [MAX_MODULUS-1:0] new_set;

   assign magnitude = req_value[VALUE_W-1] ? VALUE_W'(-req_value) : VALUE_W'(req_value);

   assign rem_shift = {rem_ff, quo_ff[VALUE_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, modulus_ff};

   // only residues below the current modulus take part
   assign valid_mask = ~({MAX_MODULUS{1'b1}} << modulus_ff);
   assign set_masked = set_ff & valid_mask;

   // rotate left by rot_amt modulo k; plus pass uses r, minus pass uses k - r
   assign rot_amt = cmd.rot_plus ? res_ff : modulus_ff - res_ff;
   assign rot_out = ((set_masked << rot_amt) | (set_masked >> (modulus_ff - rot_amt)))
                    & valid_mask;

   assign new_set = first_ff ? (MAX_MODULUS'(1) << res_ff) : (plus_ff | rot_out);

   always_comb begin
      modulus_in   = modulus_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      set_in       = set_ff;
      plus_in      = plus_ff;
      divisible_in = divisible_ff;

      if (csr_write_enable && (csr_write_data != '0)
          && (32'(csr_write_data) <= MAX_MODULUS)) begin
         modulus_in = csr_write_data;
      end
      if (cmd.load) begin
         quo_in   = magnitude;
         rem_in   = '0;
         neg_in   = req_value[VALUE_W-1];
         first_in = req_first_item;
         last_in  = req_last_item;
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
         rem_in = rem_ge ? MOD_W'(rem_shift - {1'b0, modulus_ff}) : rem_shift[MOD_W-1:0];
      end
      if (cmd.fix) begin
         // truncating remainder of a negative value folds back into 0..k-1
         res_in = (neg_ff && (rem_ff != '0)) ? modulus_ff - rem_ff : rem_ff;
      end
      if (cmd.rot_plus) begin
         plus_in = rot_out;
      end
      if (cmd.commit) begin
         set_in = new_set;
      end
      if (cmd.rsp_load) begin
         divisible_in = new_set[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_W'(1);
         set_ff     <= '0;
      end else begin
         modulus_ff <= modulus_in;
         set_ff     <= set_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      neg_ff       <= neg_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      plus_ff      <= plus_in;
      divisible_ff <= divisible_in;
   end

   assign status.item_last = last_ff;
   assign rsp_divisible    = divisible_ff;

endmodule

// ===== rtl/core/ssd_controller.sv =====
// controller: request sequencing, division step count and response valid
module ssd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ssd_pkg::ssd_status_type status,
   output ssd_pkg::ssd_cmd_type    cmd
);
   import ssd_pkg::*;

   ssd_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_blocked;

   // a verdict cannot be written while the previous one is still waiting
   assign out_blocked = status.item_last && rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_ROTP;
         end
         ST_ROTP: begin
            cmd.rot_plus = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!out_blocked) begin
               cmd.commit   = 1'b1;
               cmd.rsp_load = status.item_last;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/signed_sum_divisibility_dp_unit.sv =====
// top level of the signed-sum divisibility unit
// Each request carries one signed 16-bit value; the unit tracks which residues modulo the
// configured modulus can be reached by choosing signs and, on a request flagged last, returns
// one response telling whether residue 0 is reachable. A request is accepted, then runs through
// 16 restoring-division steps that reduce the magnitude modulo k, one sign fix, and
// two passes through the single shared rotator (set rotated by +r, then by k - r). The next
// request is taken once the current one finishes; a response waits in its output register.
// Modulus writes of 0 or above MAX_MODULUS are ignored; write it only while the unit is idle.
module signed_sum_divisibility_dp_unit #(
   parameter int MAX_MODULUS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ssd_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_first_item,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_divisible,
   input  logic                               csr_write_enable,
   input  logic [ssd_pkg::MOD_W-1:0]          csr_write_data
);
   import ssd_pkg::*;

   ssd_cmd_type    cmd;
   ssd_status_type status;

   ssd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssd_datapath #(
      .MAX_MODULUS (MAX_MODULUS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_divisible    (rsp_divisible)
   );

endmodule

// ===== tb/signed_sum_divisibility_dp_unit_tb.sv =====
// self-checking testbench for the signed-sum divisibility unit
`timescale 1ns / 100ps

module signed_sum_divisibility_dp_unit_tb;
   import ssd_pkg::*;

   localparam int MAX_MOD = 128;
   localparam int N_DIR = 30;
   localparam int N_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic signed [VALUE_W-1:0] value;
      logic                      first;
      logic                      last;
      logic                      pinned;
      logic                      pinned_div;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_first_item;
   logic                      req_last_item;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_divisible;
   logic                      csr_write_enable;
   logic [MOD_W-1:0]          csr_write_data;

   // model of the unit: current modulus and the set of reachable residues
   int               modulus_model = 1;
   logic [MAX_MOD-1:0] residue_set = '0;
   logic             verdict_q[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int err_count = 0;
   int requests_sent = 0;
   int verdicts_seen = 0;
   int cycle_count = 0;

   dir_row_type directed [N_DIR] = '{
      // nothing started yet: empty set gives 0
      '{ROW_REQUEST, 16'sd5,     1'b0, 1'b1, 1'b1, 1'b0},
      '{ROW_REQUEST, 16'sd0,     1'b1, 1'b1, 1'b1, 1'b1},
      // out-of-range modulus writes must be dropped
      '{ROW_WRITE,   16'sd0,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd129,   1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd255,   1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd7,     1'b1, 1'b1, 1'b1, 1'b1},
      '{ROW_WRITE,   16'sd128,   1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sh8000,  1'b1, 1'b1, 1'b1, 1'b1},
      '{ROW_REQUEST, 16'sh7FFF,  1'b1, 1'b1, 1'b1, 1'b0},
      '{ROW_REQUEST, -16'sd1,    1'b1, 1'b1, 1'b1, 1'b0},
      '{ROW_WRITE,   16'sd2,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd3,     1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd5,     1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd7,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd1,     1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd2,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd4,     1'b0, 1'b1, 1'b0, 1'b0},
      // requests after the last one keep folding into the same set
      '{ROW_REQUEST, 16'sd7,     1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_REQUEST, -16'sd3,    1'b0, 1'b1, 1'b0, 1'b0},
      // modulus change in the middle of a sequence
      '{ROW_WRITE,   16'sd128,   1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd100,   1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd27,    1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd3,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd1,     1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd1,     1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sh8000,  1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,   16'sd127,   1'b0, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sh7FFF,  1'b1, 1'b0, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sh8000,  1'b0, 1'b1, 1'b0, 1'b0},
      '{ROW_REQUEST, 16'sd127,   1'b1, 1'b1, 1'b1, 1'b1}
   };

   signed_sum_divisibility_dp_unit #(
      .MAX_MODULUS(MAX_MOD)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_divisible    (rsp_divisible),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // folds one value into the residue set, returns whether residue 0 is reachable
   function automatic logic advance_residues(input logic signed [VALUE_W-1:0] v,
                                             input logic first);
      logic [MAX_MOD-1:0] nxt;
      int r;
      nxt = '0;
      r = int'(v) % modulus_model;
      if (r < 0) r += modulus_model;
      if (first) begin
         nxt[r] = 1'b1;
      end else begin
         // bits at or above the modulus are dropped here
         for (int i = 0; i < modulus_model; i++) begin
            if (residue_set[i]) begin
               nxt[(i + r) % modulus_model] = 1'b1;
               nxt[(i + modulus_model - r) % modulus_model] = 1'b1;
            end
         end
      end
      residue_set = nxt;
      return nxt[0];
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3, 4, 5: return 16'(int'($urandom_range(0, 300)) - 150);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic first,
                            input logic last, input logic pinned, input logic pinned_div);
      int gap;
      logic div;
      gap = 0;
      @(negedge clock);
      if (send_idle_pct > 0) begin
         if ($urandom_range(15) == 0) gap = $urandom_range(1, 45);
         while ($urandom_range(99) < send_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= v;
      req_first_item <= first;
      req_last_item  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      div = advance_residues(v, first);
      requests_sent++;
      if (last) verdict_q = {verdict_q, (pinned ? pinned_div : div)};
   endtask

   // drop valid, let every verdict come back, then cover a request still in flight
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [MOD_W-1:0] d);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= d;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (d != 0 && d <= MAX_MOD) modulus_model = d;
   endtask

   // receiver side: random stalls, plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_response
      logic want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("response with none pending, divisible=%0b",
                                      rsp_divisible));
         end else begin
            want = verdict_q.pop_front();
            verdicts_seen++;
            if (rsp_divisible !== want)
               report_mismatch($sformatf("divisible=%0b, model says %0b",
                                         rsp_divisible, want));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                  verdict_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int sent;
      int len;
      int mode;
      logic pressure_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_value        = '0;
      req_first_item   = 1'b0;
      req_last_item    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      pressure_done    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < N_DIR; n++) begin
         if (directed[n].kind == ROW_WRITE) begin
            wait_idle();
            write_modulus(directed[n].value[MOD_W-1:0]);
         end else begin
            send_item(directed[n].value, directed[n].first, directed[n].last,
                      directed[n].pinned, directed[n].pinned_div);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         if ($urandom_range(2) == 0)
            write_modulus($urandom_range(1) ? 8'd0 : 8'($urandom_range(129, 255)));
         case (p)
            0: write_modulus(8'd128);
            1: write_modulus(8'd1);
            2: write_modulus(8'd2);
            3: write_modulus(8'd127);
            6: write_modulus(8'd3);
            default: write_modulus(8'($urandom_range(1, MAX_MOD)));
         endcase
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 68 : (mode == 3) ? 28 : 0;
         stall_pct     = (mode == 2) ? 68 : (mode == 3) ? 28 : 0;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (p == PRESSURE_PHASE && !pressure_done && sent >= 10) begin
               hold_request = HOLD_CYCLES;
               pressure_done = 1'b1;
            end
            if ($urandom_range(99) < 12) begin
               // stray request with arbitrary flags
               send_item(random_value(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'b0, 1'b0);
               sent++;
            end else begin
               len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
               for (int j = 0; j < len; j++)
                  send_item(random_value(), j == 0, j == len - 1, 1'b0, 1'b0);
               sent += len;
            end
         end
      end

      wait_idle();
      $display("%0d requests and %0d verdicts checked, %0d mismatches", requests_sent,
               verdicts_seen, err_count);
      $display("%s%s", "moduli 1 to 128 with rejected writes and a change inside a sequence, ",
               "under sender gaps, response stalls and a long response hold-off");
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ssd_pkg.sv
rtl/core/ssd_datapath.sv
rtl/core/ssd_controller.sv
rtl/core/signed_sum_divisibility_dp_unit.sv
tb/signed_sum_divisibility_dp_unit_tb.sv
